FILE: hdl/cmsh_pkg.sv
// cmsh_pkg: shared types, constants and lookup functions for the cubic m-spline
// hazard evaluator. No dependencies; imported by the alu and the top level.
`default_nettype none

package cmsh_pkg;

   // request actions
   localparam logic [1:0] ACT_KNOT   = 2'd0;
   localparam logic [1:0] ACT_WEIGHT = 2'd1;
   localparam logic [1:0] ACT_EVAL   = 2'd2;

   // register file
   localparam int         CSR_AW         = 3;
   localparam logic       REG_KNOT_COUNT = 1'b0;
   localparam logic [4:0] KC_RESET       = 5'd2;

   // fixed point constants
   localparam logic [31:0] ONE_Q30      = 32'h4000_0000;
   localparam logic [31:0] LOG2E_Q30    = 32'd1549082005;
   localparam logic [31:0] LN2_Q30      = 32'd744261118;
   localparam logic [3:0]  TAYLOR_TERMS = 4'd12;
   localparam logic [7:0]  K_SAT        = 8'sd16;
   localparam logic [7:0]  K_SHIFT      = 8'sd14;

   // alu operations
   localparam logic ALU_MUL = 1'b0;
   localparam logic ALU_DIV = 1'b1;

   // operand selectors: knot slots and the time point
   localparam logic [3:0] SEL_M3 = 4'd0;
   localparam logic [3:0] SEL_M2 = 4'd1;
   localparam logic [3:0] SEL_M1 = 4'd2;
   localparam logic [3:0] SEL_L  = 4'd3;
   localparam logic [3:0] SEL_P1 = 4'd4;
   localparam logic [3:0] SEL_P2 = 4'd5;
   localparam logic [3:0] SEL_P3 = 4'd6;
   localparam logic [3:0] SEL_P4 = 4'd7;
   localparam logic [3:0] SEL_T  = 4'd8;

   // knot differences
   localparam logic [3:0] DF_HT  = 4'd0;
   localparam logic [3:0] DF_HTM = 4'd1;
   localparam logic [3:0] DF_H2T = 4'd2;
   localparam logic [3:0] DF_HT2 = 4'd3;
   localparam logic [3:0] DF_HT3 = 4'd4;
   localparam logic [3:0] DF_HHT = 4'd5;
   localparam logic [3:0] DF_HH  = 4'd6;
   localparam logic [3:0] DF_H2  = 4'd7;
   localparam logic [3:0] DF_H3  = 4'd8;
   localparam logic [3:0] DF_H4  = 4'd9;
   localparam logic [3:0] DF_H3M = 4'd10;
   localparam logic [3:0] DF_H2N = 4'd11;
   localparam logic [3:0] DF_HN  = 4'd12;
   localparam logic [3:0] DF_HH3 = 4'd13;
   localparam logic [3:0] DF_HH2 = 4'd14;
   localparam logic [3:0] DF_H   = 4'd15;

   typedef struct packed {
      logic [3:0] a;
      logic [3:0] b;
   } diff_type;

   typedef struct packed {
      logic [3:0] num;
      logic [3:0] den;
   } ratio_type;

   typedef struct packed {
      logic [1:0] widx;
      logic       neg;
   } term_type;

   typedef struct packed {
      logic        start;
      logic        op;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] rem;
   } alu_cmd_type;

   typedef struct packed {
      logic done;
      logic busy;
   } alu_sts_type;

   function automatic diff_type diff_ops(input logic [3:0] code);
      diff_type d;
      case (code)
         DF_HT:   d = '{SEL_T,  SEL_L};
         DF_HTM:  d = '{SEL_T,  SEL_M1};
         DF_H2T:  d = '{SEL_T,  SEL_P2};
         DF_HT2:  d = '{SEL_P1, SEL_T};
         DF_HT3:  d = '{SEL_P3, SEL_T};
         DF_HHT:  d = '{SEL_T,  SEL_M2};
         DF_HH:   d = '{SEL_P1, SEL_M1};
         DF_H2:   d = '{SEL_P2, SEL_L};
         DF_H3:   d = '{SEL_P3, SEL_L};
         DF_H4:   d = '{SEL_P4, SEL_L};
         DF_H3M:  d = '{SEL_P3, SEL_M1};
         DF_H2N:  d = '{SEL_P2, SEL_M1};
         DF_HN:   d = '{SEL_P1, SEL_M2};
         DF_HH3:  d = '{SEL_P1, SEL_M3};
         DF_HH2:  d = '{SEL_P2, SEL_M2};
         default: d = '{SEL_P1, SEL_L};
      endcase
      return d;
   endfunction

   // the three ratios of each basis term
   function automatic ratio_type ratio_info(input logic [2:0] term, input logic [1:0] rat);
      ratio_type r0, r1, r2, r;
      case (term)
         3'd0: begin
            r0 = '{DF_HT, DF_H4};  r1 = '{DF_HT, DF_H3};   r2 = '{DF_HT, DF_H2};
         end
         3'd1: begin
            r0 = '{DF_HTM, DF_H3M}; r1 = '{DF_HTM, DF_H2N}; r2 = '{DF_HT2, DF_HH};
         end
         3'd2: begin
            r0 = '{DF_HTM, DF_H3M}; r1 = '{DF_HT, DF_H2};   r2 = '{DF_H2T, DF_H2N};
         end
         3'd3: begin
            r0 = '{DF_HT3, DF_H3M}; r1 = '{DF_HT, DF_H3};   r2 = '{DF_HT, DF_H2};
         end
         3'd4: begin
            r0 = '{DF_HHT, DF_HH2}; r1 = '{DF_HT2, DF_HH};  r2 = '{DF_HT2, DF_HN};
         end
         3'd5: begin
            r0 = '{DF_H2T, DF_HH2}; r1 = '{DF_HTM, DF_H2N}; r2 = '{DF_HT2, DF_HH};
         end
         3'd6: begin
            r0 = '{DF_H2T, DF_HH2}; r1 = '{DF_H2T, DF_H2N}; r2 = '{DF_HT, DF_H2};
         end
         default: begin
            r0 = '{DF_HT2, DF_HH};  r1 = '{DF_HT2, DF_HN};  r2 = '{DF_HT2, DF_HH3};
         end
      endcase
      case (rat)
         2'd0:    r = r0;
         2'd1:    r = r1;
         default: r = r2;
      endcase
      return r;
   endfunction

   // weight offset from l and the sign each basis term enters the sum with
   function automatic term_type term_info(input logic [2:0] term);
      term_type t;
      case (term)
         3'd0:    t = '{2'd3, 1'b0};
         3'd1:    t = '{2'd2, 1'b0};
         3'd2:    t = '{2'd2, 1'b1};
         3'd3:    t = '{2'd2, 1'b0};
         3'd4:    t = '{2'd1, 1'b0};
         3'd5:    t = '{2'd1, 1'b1};
         3'd6:    t = '{2'd1, 1'b0};
         default: t = '{2'd0, 1'b0};
      endcase
      return t;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/cmsh_req_if.sv
// cmsh_req_if: request channel of the hazard evaluator (load knot, load weight,
// evaluate). Standalone, no package needed.
`default_nettype none

interface cmsh_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [4:0]  slot;
   logic [31:0] load_value;
   logic [31:0] time_point;

   modport source (output valid, action, slot, load_value, time_point, input ready);
   modport sink   (input valid, action, slot, load_value, time_point, output ready);
endinterface

`default_nettype wire

FILE: hdl/cmsh_rsp_if.sv
// cmsh_rsp_if: response channel of the hazard evaluator (hazard and saturation).
// Standalone, no package needed.
`default_nettype none

interface cmsh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] hazard;
   logic        saturated;

   modport source (output valid, hazard, saturated, input ready);
   modport sink   (input valid, hazard, saturated, output ready);
endinterface

`default_nettype wire

FILE: hdl/cmsh_ram.sv
// cmsh_ram: generic single write port, single read port ram with registered read.
// No dependencies.
`default_nettype none

module cmsh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

`default_nettype wire

FILE: hdl/cmsh_alu.sv
// cmsh_alu: shared arithmetic unit, a 32x32 multiplier with a registered result
// and a radix-2 restoring divider. Depends on cmsh_pkg.
`default_nettype none

module cmsh_alu import cmsh_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire alu_cmd_type cmd,
   output alu_sts_type      sts,
   output logic [63:0]      res
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] low_ff, low_in;
   logic [31:0] den_ff, den_in;
   logic [31:0] quo_ff, quo_in;
   logic [63:0] res_ff, res_in;
   logic [32:0] shifted;
   logic        qbit;

   // multiply a by b, or divide: quotient of {rem, b} by a, caller guarantees rem < a
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      res_in  = res_ff;
      shifted = {rem_ff, low_ff[31]};
      qbit    = shifted >= {1'b0, den_ff};
      if (cmd.start) begin
         if (cmd.op == ALU_MUL) begin
            res_in  = cmd.a * cmd.b;
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
            cnt_in  = '0;
            rem_in  = cmd.rem;
            low_in  = cmd.b;
            den_in  = cmd.a;
         end
      end else if (busy_ff) begin
         rem_in = qbit ? 32'(shifted - {1'b0, den_ff}) : shifted[31:0];
         quo_in = {quo_ff[30:0], qbit};
         low_in = {low_ff[30:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = {32'd0, quo_ff[30:0], qbit};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      res_ff <= res_in;
   end

   assign sts.done = done_ff;
   assign sts.busy = busy_ff;
   assign res      = res_ff;
endmodule

`default_nettype wire

FILE: hdl/cubic_mspline_hazard_eval.sv
// cubic_mspline_hazard_eval: exp of a cubic m-spline hazard in fixed point.
// Depends on cmsh_pkg, cmsh_req_if, cmsh_rsp_if, cmsh_ram and cmsh_alu.
//
// Usage: a request carries an action. Load knot and load weight write slot of
// the knot or weight table and give no response; a slot past the table is
// dropped, as is the unused action. An evaluate request gives one response with
// the hazard (Q16.16) and a saturation flag. knot_count is written over the apb
// port at address 0; the user must write it only while the block is idle, the
// block itself does not enforce it. An evaluate scans the knots to find the
// interval and fetches knots and weights over the single ram read ports, then
// works out each of the 24 ratios with a divide and each product with a multiply
// on the shared divider and multiplier, and then the exponential (twelve series
// terms, each a multiply and a divide); it ends early when the time is the last
// knot or a saturation ends the work.
// Requests are taken only while the sequencer is idle.
// The response sits in an output register; the next request is taken while it
// waits, and a following evaluate holds its result until the register frees.
// Reset clears knot_count to 2 and the control state; the tables keep their
// contents and must be loaded before use.
`default_nettype none

module cubic_mspline_hazard_eval import cmsh_pkg::*; #(
   parameter int MAX_KNOTS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   cmsh_req_if.sink               req_ch,
   cmsh_rsp_if.source             rsp_ch,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [31:0]       pwdata,
   output logic      [31:0]       prdata,
   output logic                   pready
);
   localparam int KI = $clog2(MAX_KNOTS);
   localparam int WD = MAX_KNOTS + 2;
   localparam int WI = $clog2(WD);

   localparam logic [4:0] ST_IDLE      = 5'd0;
   localparam logic [4:0] ST_SCAN_RD   = 5'd1;
   localparam logic [4:0] ST_SCAN_CMP  = 5'd2;
   localparam logic [4:0] ST_KF_RD     = 5'd3;
   localparam logic [4:0] ST_KF_CAP    = 5'd4;
   localparam logic [4:0] ST_WF_RD     = 5'd5;
   localparam logic [4:0] ST_WF_CAP    = 5'd6;
   localparam logic [4:0] ST_PREP      = 5'd7;
   localparam logic [4:0] ST_RAT_START = 5'd8;
   localparam logic [4:0] ST_RAT_WAIT  = 5'd9;
   localparam logic [4:0] ST_MUL_WAIT  = 5'd10;
   localparam logic [4:0] ST_WT_WAIT   = 5'd11;
   localparam logic [4:0] ST_X_CHK     = 5'd12;
   localparam logic [4:0] ST_X_WAIT    = 5'd13;
   localparam logic [4:0] ST_EXP_MUL   = 5'd14;
   localparam logic [4:0] ST_EXP_F     = 5'd15;
   localparam logic [4:0] ST_EXP_U     = 5'd16;
   localparam logic [4:0] ST_TAY_MUL   = 5'd17;
   localparam logic [4:0] ST_TAY_DIV   = 5'd18;
   localparam logic [4:0] ST_EXP_END   = 5'd19;
   localparam logic [4:0] ST_FIN       = 5'd20;
   localparam logic [4:0] ST_OUT       = 5'd21;

   logic [4:0]  state_ff, state_in;
   logic [4:0]  kc_ff;
   logic [31:0] t_ff, t_in;
   logic [KI-1:0] j_ff, j_in, l_ff, l_in;
   logic [31:0] prev_ff, prev_in;
   logic        teq_ff, teq_in;
   logic [2:0]  s_ff, s_in;
   logic [31:0] kv_ff [8];
   logic [31:0] wv_ff [4];
   logic [2:0]  term_ff, term_in;
   logic [1:0]  rat_ff, rat_in;
   logic [31:0] pmag_ff, pmag_in;
   logic        psgn_ff, psgn_in, rsgn_ff, rsgn_in;
   logic signed [37:0] acc_ff, acc_in;
   logic        neg_ff, neg_in;
   logic [31:0] y_ff, y_in;
   logic [29:0] u_ff, u_in;
   logic [31:0] m_ff, m_in;
   logic [3:0]  i_ff, i_in;
   logic [31:0] hz_ff, hz_in;
   logic        sat_ff, sat_in;
   logic        rv_ff, rv_in;
   logic [31:0] rhz_ff, rhz_in;
   logic        rsat_ff, rsat_in;

   logic [6:0]  kc7, n_w, last_w;
   logic [7:0]  l8, last8, kidx8;
   logic [KI-1:0] kaddr;
   logic [WI-1:0] waddr_rd;
   logic [31:0] k_rdata, w_rdata;
   logic        k_we, w_we, req_acc, rsp_acc, cfg_we;

   ratio_type   rinfo;
   term_type    tinfo;
   diff_type    dn, dd, dh;
   logic [32:0] nd, ddf, hd;
   logic [31:0] nmag, dmag, hmag, wsel, wmag;
   logic        nneg, dneg, hneg, wneg;
   logic [36:0] smag;
   logic [33:0] tmag;
   logic [29:0] ymag;
   logic signed [7:0] kexp;
   logic [7:0]  sh;
   logic [39:0] rnd;

   alu_cmd_type alu_cmd;
   alu_sts_type alu_sts;
   logic [63:0] alu_res;

   function automatic logic [31:0] opnd(input logic [3:0] sel);
      return (sel == SEL_T) ? t_ff : kv_ff[sel[2:0]];
   endfunction

   // configuration
   assign cfg_we = psel && penable && pwrite && (paddr[CSR_AW-1] == REG_KNOT_COUNT);
   assign prdata = (paddr[CSR_AW-1] == REG_KNOT_COUNT) ? {27'd0, kc_ff} : 32'd0;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kc_ff <= KC_RESET;
      end else if (cfg_we) begin
         kc_ff <= pwdata[4:0];
      end
   end

   assign kc7    = 7'(kc_ff);
   assign n_w    = (kc7 < 7'd2) ? 7'd2 : ((kc7 > 7'(MAX_KNOTS)) ? 7'(MAX_KNOTS) : kc7);
   assign last_w = n_w - 7'd1;

   // handshakes and table writes
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign rsp_acc      = rv_ff && rsp_ch.ready;
   assign k_we = req_acc && (req_ch.action == ACT_KNOT) && (7'(req_ch.slot) < 7'(MAX_KNOTS));
   assign w_we = req_acc && (req_ch.action == ACT_WEIGHT) && (7'(req_ch.slot) < 7'(WD));

   // clamped neighbour index for knot fetch slot s
   assign l8    = 8'(l_ff);
   assign last8 = 8'(last_w);
   always_comb begin
      case (s_ff)
         3'd0:    kidx8 = (l8 >= 8'd3) ? l8 - 8'd3 : 8'd0;
         3'd1:    kidx8 = (l8 >= 8'd2) ? l8 - 8'd2 : 8'd0;
         3'd2:    kidx8 = (l8 >= 8'd1) ? l8 - 8'd1 : 8'd0;
         3'd3:    kidx8 = l8;
         default: kidx8 = (l8 + 8'(s_ff) - 8'd3 > last8) ? last8 : l8 + 8'(s_ff) - 8'd3;
      endcase
   end
   assign kaddr    = (state_ff == ST_SCAN_RD) ? j_ff : KI'(kidx8);
   assign waddr_rd = WI'(l_ff) + WI'(s_ff[1:0]);

   cmsh_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_knot_ram (
      .clock (clock),
      .we    (k_we),
      .waddr (KI'(req_ch.slot)),
      .wdata (req_ch.load_value),
      .raddr (kaddr),
      .rdata (k_rdata)
   );

   cmsh_ram #(.WIDTH(32), .DEPTH(WD)) u_weight_ram (
      .clock (clock),
      .we    (w_we),
      .waddr (WI'(req_ch.slot)),
      .wdata (req_ch.load_value),
      .raddr (waddr_rd),
      .rdata (w_rdata)
   );

   cmsh_alu u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (alu_cmd),
      .sts   (alu_sts),
      .res   (alu_res)
   );

   // operand differences for the current ratio and for h
   assign rinfo = ratio_info(term_ff, rat_ff);
   assign tinfo = term_info(term_ff);
   assign dn    = diff_ops(rinfo.num);
   assign dd    = diff_ops(rinfo.den);
   assign dh    = diff_ops(DF_H);
   assign nd    = {1'b0, opnd(dn.a)} - {1'b0, opnd(dn.b)};
   assign ddf   = {1'b0, opnd(dd.a)} - {1'b0, opnd(dd.b)};
   assign hd    = {1'b0, opnd(dh.a)} - {1'b0, opnd(dh.b)};
   assign nneg  = nd[32];
   assign dneg  = ddf[32];
   assign hneg  = hd[32];
   assign nmag  = nneg ? 32'(33'd0 - nd) : nd[31:0];
   assign dmag  = dneg ? 32'(33'd0 - ddf) : ddf[31:0];
   assign hmag  = hneg ? 32'(33'd0 - hd) : hd[31:0];
   assign wsel  = wv_ff[tinfo.widx];
   assign wneg  = wsel[31];
   assign wmag  = wneg ? 32'd0 - wsel : wsel;
   assign smag  = acc_ff[37] ? 37'(-acc_ff) : 37'(acc_ff);
   assign tmag  = alu_res[63:30];
   assign ymag  = 30'(alu_res[58:30]) + 30'(neg_ff && (alu_res[29:0] != 30'd0));
   assign kexp  = y_ff[31:24];
   assign sh    = K_SHIFT - kexp;
   assign rnd   = ({8'd0, m_ff} + (40'd1 << (sh[5:0] - 6'd1))) >> sh[5:0];

   always_comb begin
      state_in = state_ff;
      t_in     = t_ff;
      j_in     = j_ff;
      l_in     = l_ff;
      prev_in  = prev_ff;
      teq_in   = teq_ff;
      s_in     = s_ff;
      term_in  = term_ff;
      rat_in   = rat_ff;
      pmag_in  = pmag_ff;
      psgn_in  = psgn_ff;
      rsgn_in  = rsgn_ff;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      y_in     = y_ff;
      u_in     = u_ff;
      m_in     = m_ff;
      i_in     = i_ff;
      hz_in    = hz_ff;
      sat_in   = sat_ff;
      rv_in    = rv_ff && !rsp_acc;
      rhz_in   = rhz_ff;
      rsat_in  = rsat_ff;
      alu_cmd  = '{1'b0, ALU_MUL, 32'd0, 32'd0, 32'd0};

      case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_ch.action == ACT_EVAL)) begin
               t_in     = req_ch.time_point;
               j_in     = '0;
               l_in     = '0;
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: state_in = ST_SCAN_CMP;
         ST_SCAN_CMP: begin
            // last interval with knot[j-1] <= t < knot[j] wins
            if ((j_ff != '0) && (prev_ff <= t_ff) && (t_ff < k_rdata)) begin
               l_in = j_ff - KI'(1);
            end
            prev_in = k_rdata;
            if (7'(j_ff) == last_w) begin
               teq_in = (t_ff == k_rdata);
               if (t_ff == k_rdata) begin
                  l_in = KI'(last_w - 7'd1);
               end
               s_in     = 3'd0;
               state_in = ST_KF_RD;
            end else begin
               j_in     = j_ff + KI'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_KF_RD: state_in = ST_KF_CAP;
         ST_KF_CAP: begin
            s_in = s_ff + 3'd1;
            if (s_ff == 3'd7) begin
               s_in     = 3'd0;
               state_in = ST_WF_RD;
            end else begin
               state_in = ST_KF_RD;
            end
         end
         ST_WF_RD: state_in = ST_WF_CAP;
         ST_WF_CAP: begin
            s_in     = s_ff + 3'd1;
            state_in = (s_ff == 3'd3) ? ST_PREP : ST_WF_RD;
         end
         ST_PREP: begin
            term_in = 3'd0;
            rat_in  = 2'd0;
            if (teq_ff) begin
               // end of range: the sum is the last weight itself
               acc_in   = 38'(signed'(wv_ff[3]));
               state_in = ST_X_CHK;
            end else begin
               acc_in   = '0;
               state_in = ST_RAT_START;
            end
         end
         ST_RAT_START: begin
            rsgn_in = nneg ^ dneg;
            if ((dmag == 32'd0) || ({2'd0, nmag} >= {dmag, 2'd0})) begin
               state_in = ST_FIN;
            end else begin
               alu_cmd  = '{1'b1, ALU_DIV, dmag, {nmag[1:0], 30'd0}, {2'd0, nmag[31:2]}};
               state_in = ST_RAT_WAIT;
            end
         end
         ST_RAT_WAIT: begin
            if (alu_sts.done) begin
               if (rat_ff == 2'd0) begin
                  pmag_in  = alu_res[31:0];
                  psgn_in  = rsgn_ff;
                  rat_in   = 2'd1;
                  state_in = ST_RAT_START;
               end else begin
                  psgn_in  = psgn_ff ^ rsgn_ff;
                  alu_cmd  = '{1'b1, ALU_MUL, pmag_ff, alu_res[31:0], 32'd0};
                  state_in = ST_MUL_WAIT;
               end
            end
         end
         ST_MUL_WAIT: begin
            if (alu_sts.done) begin
               if (alu_res[63:62] != 2'd0) begin
                  state_in = ST_FIN;
               end else begin
                  pmag_in = alu_res[61:30];
                  if (rat_ff == 2'd2) begin
                     alu_cmd  = '{1'b1, ALU_MUL, wmag, alu_res[61:30], 32'd0};
                     state_in = ST_WT_WAIT;
                  end else begin
                     rat_in   = rat_ff + 2'd1;
                     state_in = ST_RAT_START;
                  end
               end
            end
         end
         ST_WT_WAIT: begin
            if (alu_sts.done) begin
               if (wneg ^ psgn_ff ^ tinfo.neg) begin
                  acc_in = acc_ff - signed'(38'(tmag));
               end else begin
                  acc_in = acc_ff + signed'(38'(tmag));
               end
               rat_in = 2'd0;
               if (term_ff == 3'd7) begin
                  state_in = ST_X_CHK;
               end else begin
                  term_in  = term_ff + 3'd1;
                  state_in = ST_RAT_START;
               end
            end
         end
         ST_X_CHK: begin
            neg_in = acc_ff[37] ^ hneg;
            if (hmag == 32'd0) begin
               state_in = ST_FIN;
            end else if (42'(smag) >= {hmag, 10'd0}) begin
               // exponent at or beyond 16 in magnitude
               if (acc_ff[37] ^ hneg) begin
                  hz_in    = 32'd0;
                  sat_in   = 1'b0;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_FIN;
               end
            end else begin
               alu_cmd  = '{1'b1, ALU_DIV, hmag, {smag[13:0], 18'd0}, 32'(smag[36:14])};
               state_in = ST_X_WAIT;
            end
         end
         ST_X_WAIT: begin
            if (alu_sts.done) begin
               alu_cmd  = '{1'b1, ALU_MUL, {4'd0, alu_res[27:0]}, LOG2E_Q30, 32'd0};
               state_in = ST_EXP_MUL;
            end
         end
         ST_EXP_MUL: begin
            if (alu_sts.done) begin
               // floor of x*log2e, rounding the magnitude up when negative
               y_in     = neg_ff ? 32'd0 - 32'(ymag) : 32'(ymag);
               state_in = ST_EXP_F;
            end
         end
         ST_EXP_F: begin
            alu_cmd  = '{1'b1, ALU_MUL, {8'd0, y_ff[23:0]}, LN2_Q30, 32'd0};
            state_in = ST_EXP_U;
         end
         ST_EXP_U: begin
            if (alu_sts.done) begin
               u_in     = alu_res[53:24];
               m_in     = ONE_Q30;
               i_in     = 4'd1;
               alu_cmd  = '{1'b1, ALU_MUL, ONE_Q30, {2'd0, alu_res[53:24]}, 32'd0};
               state_in = ST_TAY_MUL;
            end
         end
         ST_TAY_MUL: begin
            if (alu_sts.done) begin
               alu_cmd  = '{1'b1, ALU_DIV, {28'd0, i_ff}, alu_res[61:30], 32'd0};
               state_in = ST_TAY_DIV;
            end
         end
         ST_TAY_DIV: begin
            if (alu_sts.done) begin
               m_in = m_ff + alu_res[31:0];
               if (i_ff == TAYLOR_TERMS) begin
                  state_in = ST_EXP_END;
               end else begin
                  i_in     = i_ff + 4'd1;
                  alu_cmd  = '{1'b1, ALU_MUL, alu_res[31:0], {2'd0, u_ff}, 32'd0};
                  state_in = ST_TAY_MUL;
               end
            end
         end
         ST_EXP_END: begin
            sat_in   = 1'b0;
            state_in = ST_OUT;
            if (kexp >= signed'(K_SAT)) begin
               hz_in  = 32'hFFFF_FFFF;
               sat_in = 1'b1;
            end else if (kexp > signed'(K_SHIFT)) begin
               hz_in = {m_ff[30:0], 1'b0};
            end else if (kexp == signed'(K_SHIFT)) begin
               hz_in = m_ff;
            end else begin
               hz_in = rnd[31:0];
            end
         end
         ST_FIN: begin
            hz_in    = 32'hFFFF_FFFF;
            sat_in   = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rv_ff || rsp_acc) begin
               rv_in    = 1'b1;
               rhz_in   = hz_ff;
               rsat_in  = sat_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
      end
      t_ff    <= t_in;
      j_ff    <= j_in;
      l_ff    <= l_in;
      prev_ff <= prev_in;
      teq_ff  <= teq_in;
      s_ff    <= s_in;
      term_ff <= term_in;
      rat_ff  <= rat_in;
      pmag_ff <= pmag_in;
      psgn_ff <= psgn_in;
      rsgn_ff <= rsgn_in;
      acc_ff  <= acc_in;
      neg_ff  <= neg_in;
      y_ff    <= y_in;
      u_ff    <= u_in;
      m_ff    <= m_in;
      i_ff    <= i_in;
      hz_ff   <= hz_in;
      sat_ff  <= sat_in;
      rhz_ff  <= rhz_in;
      rsat_ff <= rsat_in;
      if (state_ff == ST_KF_CAP) begin
         kv_ff[s_ff] <= k_rdata;
      end
      if (state_ff == ST_WF_CAP) begin
         wv_ff[s_ff[1:0]] <= w_rdata;
      end
   end

   assign rsp_ch.valid     = rv_ff;
   assign rsp_ch.hazard    = rhz_ff;
   assign rsp_ch.saturated = rsat_ff;

   a_sat_all_ones: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rsat_ff |-> rhz_ff == 32'hFFFF_FFFF)
      else $error("saturated response without full-scale hazard");

   a_eval_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_acc && (req_ch.action == ACT_EVAL) |=> state_ff == ST_SCAN_RD)
      else $error("evaluate request did not start the interval scan");

   a_alu_no_overlap: assert property (@(posedge clock) disable iff (reset)
      alu_cmd.start |-> !alu_sts.busy)
      else $error("alu started while a divide is in progress");

   a_no_req_when_busy: assert property (@(posedge clock) disable iff (reset)
      alu_sts.busy |-> !req_ch.ready)
      else $error("request channel open while the alu is working");
endmodule

`default_nettype wire

FILE: tb/cmsh_checker.sv
// cmsh_checker: watches the request and response channels of the hazard
// evaluator, predicts each hazard and compares. Depends on cmsh_pkg and the
// cmsh_req_if / cmsh_rsp_if interfaces.
`default_nettype none

module cmsh_checker import cmsh_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   cmsh_req_if.sink         req_mon,
   cmsh_rsp_if.sink         rsp_mon,
   input  wire logic [4:0]  knot_count,
   output int               fail_count
);

   typedef struct {
      logic [31:0] hazard;
      logic        saturated;
   } hazard_type;

   logic [31:0] knots [16];
   logic [31:0] weights [18];
   hazard_type  pending_hazards [$];
   bit          sat_flag;

   function automatic longint unsigned absval(longint v);
      return v < 0 ? longint'(0) - v : v;
   endfunction

   function automatic longint apply_sign(longint unsigned m, bit neg);
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint q30_ratio(longint n, longint d);
      longint unsigned q;
      if (d == 0) begin
         sat_flag = 1;
         return 0;
      end
      q = (absval(n) << 30) / absval(d);
      if (q >= 64'h1_0000_0000) begin
         sat_flag = 1;
         return 0;
      end
      return apply_sign(q, (n < 0) != (d < 0));
   endfunction

   function automatic longint q30_mul(longint a, longint b);
      longint unsigned p;
      p = (absval(a) * absval(b)) >> 30;
      if (p >= 64'h1_0000_0000) begin
         sat_flag = 1;
         return 0;
      end
      return apply_sign(p, (a < 0) != (b < 0));
   endfunction

   function automatic longint basis(longint n1, longint d1, longint n2, longint d2,
                                    longint n3, longint d3);
      longint r1, r2, r3;
      r1 = q30_ratio(n1, d1);
      r2 = q30_ratio(n2, d2);
      r3 = q30_ratio(n3, d3);
      return q30_mul(q30_mul(r1, r2), r3);
   endfunction

   function automatic longint weighted(logic [31:0] w, longint p);
      longint ws;
      longint unsigned m;
      ws = longint'($signed(w));
      m = (absval(ws) * absval(p)) >> 30;
      return apply_sign(m, (ws < 0) != (p < 0));
   endfunction

   function automatic longint floor_shr(longint v, int s);
      if (v >= 0) return longint'($unsigned(v) >> s);
      return -longint'((absval(v) + ((64'd1 << s) - 1)) >> s);
   endfunction

   function automatic logic [31:0] exp_fixed(longint x);
      longint y, k;
      longint unsigned f, u, term, m;
      int s;
      y = floor_shr(x * longint'(LOG2E_Q30), 30);
      k = floor_shr(y, 24);
      f = $unsigned(y - k * 16777216);
      u = (f * LN2_Q30) >> 24;
      term = 64'd1 << 30;
      m = term;
      for (int i = 1; i <= 12; i++) begin
         term = ((term * u) >> 30) / i;
         m += term;
      end
      if (k >= 16) begin
         sat_flag = 1;
         return 32'hFFFF_FFFF;
      end
      if (k >= 14) return 32'(m << (k - 14));
      s = int'(14 - k);
      return 32'((m + (64'd1 << (s - 1))) >> s);
   endfunction

   function automatic longint kd(logic [31:0] a, logic [31:0] b);
      return longint'({32'd0, a}) - longint'({32'd0, b});
   endfunction

   function automatic hazard_type predict_hazard(logic [31:0] t);
      hazard_type r;
      int n, lst, l, m1, m2, m3, p1, p2, p3, p4;
      longint s, h, ht, htm, h2t, ht2, ht3, hht, hh, h2, h3, h4, h3m, h2n, hn, hh3, hh2;
      longint unsigned rm;
      bit neg;
      n = knot_count < 2 ? 2 : (knot_count > 16 ? 16 : knot_count);
      lst = n - 1;
      l = 0;
      for (int k = 1; k < n; k++)
         if (knots[k-1] <= t && t < knots[k]) l = k - 1;
      sat_flag = 0;
      r.hazard = 0;
      if (t == knots[lst]) begin
         l = n - 2;
         s = weighted(weights[l+3], 64'd1 << 30);
         h = kd(knots[l+1], knots[l]);
      end else begin
         m1 = l > 0 ? l - 1 : 0;
         m2 = l > 1 ? l - 2 : 0;
         m3 = l > 2 ? l - 3 : 0;
         p1 = l + 1 > lst ? lst : l + 1;
         p2 = l + 2 > lst ? lst : l + 2;
         p3 = l + 3 > lst ? lst : l + 3;
         p4 = l + 4 > lst ? lst : l + 4;
         ht = kd(t, knots[l]);        htm = kd(t, knots[m1]);       h2t = kd(t, knots[p2]);
         ht2 = kd(knots[p1], t);      ht3 = kd(knots[p3], t);       hht = kd(t, knots[m2]);
         hh = kd(knots[p1], knots[m1]); h2 = kd(knots[p2], knots[l]);
         h3 = kd(knots[p3], knots[l]);  h4 = kd(knots[p4], knots[l]);
         h3m = kd(knots[p3], knots[m1]); h2n = kd(knots[p2], knots[m1]);
         hn = kd(knots[p1], knots[m2]);  hh3 = kd(knots[p1], knots[m3]);
         hh2 = kd(knots[p2], knots[m2]);
         h = kd(knots[p1], knots[l]);
         s = weighted(weights[l+3], basis(ht, h4, ht, h3, ht, h2))
           + weighted(weights[l+2], basis(htm, h3m, htm, h2n, ht2, hh))
           - weighted(weights[l+2], basis(htm, h3m, ht, h2, h2t, h2n))
           + weighted(weights[l+2], basis(ht3, h3m, ht, h3, ht, h2))
           + weighted(weights[l+1], basis(hht, hh2, ht2, hh, ht2, hn))
           - weighted(weights[l+1], basis(h2t, hh2, htm, h2n, ht2, hh))
           + weighted(weights[l+1], basis(h2t, hh2, h2t, h2n, ht, h2))
           + weighted(weights[l], basis(ht2, hh, ht2, hn, ht2, hh3));
      end
      if (h == 0) sat_flag = 1;
      if (!sat_flag) begin
         rm = (absval(s) << 18) / absval(h);
         neg = (s < 0) != (h < 0);
         if (rm >= (64'd16 << 24)) begin
            if (!neg) sat_flag = 1;
         end else begin
            r.hazard = exp_fixed(apply_sign(rm, neg));
         end
      end
      if (sat_flag) r.hazard = 32'hFFFF_FFFF;
      r.saturated = sat_flag;
      return r;
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   always @(posedge clock) begin
      hazard_type got, want;
      if (reset) begin
         fail_count = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            case (req_mon.action)
               ACT_KNOT:   if (req_mon.slot < 16) knots[req_mon.slot[3:0]] = req_mon.load_value;
               ACT_WEIGHT: if (req_mon.slot < 18) weights[req_mon.slot] = req_mon.load_value;
               ACT_EVAL:   pending_hazards.push_back(predict_hazard(req_mon.time_point));
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.hazard = rsp_mon.hazard;
            got.saturated = rsp_mon.saturated;
            if (pending_hazards.size() == 0) begin
               report_mismatch("response with no evaluate request pending");
            end else begin
               want = pending_hazards.pop_front();
               if (got.hazard !== want.hazard)
                  report_mismatch($sformatf("hazard %h, expected %h", got.hazard, want.hazard));
               if (got.saturated !== want.saturated)
                  report_mismatch($sformatf("saturated %b, expected %b", got.saturated,
                                            want.saturated));
            end
         end
      end
   end

   function automatic int outstanding();
      return pending_hazards.size();
   endfunction

   task automatic flag_leftovers();
      if (pending_hazards.size() != 0)
         report_mismatch($sformatf("%0d hazards never returned", pending_hazards.size()));
   endtask

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// testbench: stimulus and verdict for cubic_mspline_hazard_eval. Depends on
// cmsh_pkg, both channel interfaces, the block and cmsh_checker.
`default_nettype none

module testbench;
   import cmsh_pkg::*;

   // action code the block ignores
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   logic        clock;
   logic        reset;
   logic        psel, penable, pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [31:0] pwdata, prdata;
   logic        pready;
   logic [4:0]  knot_count;
   int          fail_count;
   int          idle_cycles;
   int          accepted;
   bit          calm;
   int          n_knots;

   cmsh_req_if req_ch ();
   cmsh_rsp_if rsp_ch ();

   cubic_mspline_hazard_eval uut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   cmsh_checker u_checker (
      .clock(clock), .reset(reset), .req_mon(req_ch.sink), .rsp_mon(rsp_ch.sink),
      .knot_count(knot_count), .fail_count(fail_count)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // response stall and watchdog
   always @(negedge clock) begin
      rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 29);
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("watchdog expired");
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic csr_write(logic [4:0] value);
      @(negedge clock);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= {27'd0, value};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      knot_count = value;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   task automatic send(logic [1:0] act, logic [4:0] slot, logic [31:0] val, logic [31:0] t);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 29) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.action <= act; req_ch.slot <= slot;
      req_ch.load_value <= val; req_ch.time_point <= t;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      accepted++;
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   task automatic drain();
      while (u_checker.outstanding() != 0) @(posedge clock);
      repeat (1600) @(posedge clock);
   endtask

   // non-falling knots with small steps so ratios stay in range most of the time
   task automatic load_table(int n, int step);
      logic [31:0] k;
      k = $urandom_range(3) << 16;
      for (int i = 0; i < 16; i++) begin
         send(ACT_KNOT, 5'(i), k, 0);
         k += (i < n) ? ((step == 0) ? 32'd0 : 32'($urandom_range(step, 1))) : 32'd0;
      end
      for (int i = 0; i < 18; i++)
         send(ACT_WEIGHT, 5'(i), $urandom_range(1) ? {{7{1'b0}}, 25'($urandom)}
                                                 : -{{7{1'b0}}, 25'($urandom)}, 0);
   endtask

   function automatic logic [31:0] pick_time(int n);
      int r;
      r = $urandom_range(9);
      return r < 7 ? 32'($urandom_range(n + 2) << 16) + 32'($urandom_range(65535))
           : (r == 7 ? 32'hFFFF_FFFF : 32'($urandom_range(n) << 16));
   endfunction

   initial begin
      reset = 1'b1; calm = 1'b0; accepted = 0; knot_count = KC_RESET;
      psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
      req_ch.valid = 0; req_ch.action = ACT_KNOT; req_ch.slot = 0;
      req_ch.load_value = 0; req_ch.time_point = 0;
      rsp_ch.ready = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: table fill, full range weights, edges of time and slots
      for (int i = 0; i < 16; i++) send(ACT_KNOT, 5'(i), 32'(i) << 16, 0);
      for (int i = 0; i < 18; i++) send(ACT_WEIGHT, 5'(i), i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF, 0);
      send(ACT_WEIGHT, 5'd31, 32'hFFFF_FFFF, 0);
      send(ACT_KNOT, 5'd16, 32'hFFFF_FFFF, 0);
      send(ACT_UNUSED, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(ACT_EVAL, 0, 0, 32'h0000_0000);
      send(ACT_EVAL, 0, 0, 32'h0001_0000);
      send(ACT_EVAL, 0, 0, 32'hFFFF_FFFF);
      send(ACT_EVAL, 0, 0, 32'h0000_8000);
      drain();
      csr_write(5'd16);
      send(ACT_EVAL, 0, 0, 32'h000F_0000);
      send(ACT_EVAL, 0, 0, 32'h0007_8000);
      drain();
      csr_write(5'd31);
      send(ACT_EVAL, 0, 0, 32'h000F_0000);
      drain();
      csr_write(5'd0);
      send(ACT_EVAL, 0, 0, 32'h0000_4000);
      drain();

      // random phases; a calm stretch in the middle
      for (int ph = 0; ph < 24; ph++) begin
         calm = (ph == 10 || ph == 11);
         n_knots = (ph % 6 == 0) ? 16 : (ph % 6 == 1 ? 2 : $urandom_range(16, 2));
         csr_write(ph % 5 == 4 ? 5'($urandom_range(31)) : 5'(n_knots));
         load_table(n_knots, ph % 8 == 7 ? 0 : 32'h3_0000);
         for (int i = 0; i < 34; i++) begin
            case ($urandom_range(9))
               0: send(ACT_KNOT, 5'($urandom_range(31, 16)), $urandom, $urandom);
               1: send(ACT_WEIGHT, 5'($urandom_range(31, 18)), $urandom, $urandom);
               2: send(ACT_UNUSED, 5'($urandom), $urandom, $urandom);
               3: send(ACT_WEIGHT, 5'($urandom_range(17)), $urandom, 0);
               default: send(ACT_EVAL, 5'($urandom), $urandom, pick_time(n_knots));
            endcase
         end
         drain();
      end
      calm = 1'b0;
      u_checker.flag_leftovers();
      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire
